/* hw/rtl/ssdm_pkg.sv */
// shared types and constants for the suffix dictionary matcher
`default_nettype none
package ssdm_pkg;
  localparam int NodeCount  = 1024;
  localparam int MaxWordLen = 32;
  localparam int Alphabet   = 26;
  localparam int NodeW      = $clog2(NodeCount);
  localparam int FreeW      = $clog2(NodeCount + 1);
  localparam int LenW       = $clog2(MaxWordLen + 1);
  localparam int PosW       = (MaxWordLen > 1) ? $clog2(MaxWordLen) : 1;
  localparam int LetterW    = 5;
  localparam int LetW       = $clog2(Alphabet);
  localparam int SlotCount  = NodeCount * Alphabet;
  localparam int SlotW      = $clog2(SlotCount);

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusLong = 2'd2;

  typedef enum logic [3:0] {
    StClear, StIdle, StInsRead, StInsWait, StInsDo,
    StQryStart, StQryRead, StQryWait, StQryStep, StDone
  } state_e;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic ins_read;
    logic ins_do;
    logic qry_start;
    logic qry_read;
    logic qry_step;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic qry_stop;
  } sts_t;
endpackage
`default_nettype wire

/* hw/rtl/ssdm_ctrl.sv */
// sequencing state machine for the matcher
`default_nettype none
module ssdm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ssdm_pkg::cmd_t     cmd_o,
  input  wire ssdm_pkg::sts_t sts_i
);
  ssdm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ssdm_pkg::StClear;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssdm_pkg::StClear:    if (sts_i.clear_last) state_d = ssdm_pkg::StIdle;
      ssdm_pkg::StIdle: begin
        if (in_valid_i) state_d = ssdm_pkg::StInsRead;
      end
      ssdm_pkg::StInsRead: begin
        state_d = sts_i.is_query ? ssdm_pkg::StQryStart : ssdm_pkg::StInsWait;
      end
      ssdm_pkg::StInsWait:  state_d = ssdm_pkg::StInsDo;
      ssdm_pkg::StInsDo:    state_d = ssdm_pkg::StDone;
      ssdm_pkg::StQryStart: state_d = ssdm_pkg::StQryRead;
      ssdm_pkg::StQryRead: begin
        state_d = sts_i.qry_stop ? ssdm_pkg::StDone : ssdm_pkg::StQryWait;
      end
      ssdm_pkg::StQryWait:  state_d = ssdm_pkg::StQryStep;
      ssdm_pkg::StQryStep: begin
        state_d = sts_i.qry_stop ? ssdm_pkg::StDone : ssdm_pkg::StQryRead;
      end
      ssdm_pkg::StDone: if (out_ready_i) state_d = ssdm_pkg::StIdle;
      default:              state_d = ssdm_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ssdm_pkg::StClear:    cmd_o.clear_step = 1'b1;
      ssdm_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ssdm_pkg::StInsRead:  cmd_o.ins_read = 1'b1;
      ssdm_pkg::StInsDo:    cmd_o.ins_do = 1'b1;
      ssdm_pkg::StQryStart: cmd_o.qry_start = 1'b1;
      ssdm_pkg::StQryRead:  cmd_o.qry_read = 1'b1;
      ssdm_pkg::StQryStep:  cmd_o.qry_step = 1'b1;
      ssdm_pkg::StDone:     out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* hw/rtl/ssdm_dp.sv */
// node table, end flags, history ring and insert/walk registers
`default_nettype none
module ssdm_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ssdm_pkg::cmd_t              cmd_i,
  output ssdm_pkg::sts_t                   sts_o,
  input  wire logic                        command_i,
  input  wire logic [ssdm_pkg::LetterW-1:0] letter_i,
  input  wire logic                        word_end_i,
  output logic                             match_o,
  output logic [1:0]                       status_o
);
  localparam int NodeW = ssdm_pkg::NodeW;
  localparam int SlotW = ssdm_pkg::SlotW;
  localparam int PosW  = ssdm_pkg::PosW;
  localparam int LenW  = ssdm_pkg::LenW;

  logic [NodeW-1:0] child_mem [ssdm_pkg::SlotCount];
  logic             end_mem   [ssdm_pkg::NodeCount];
  logic [ssdm_pkg::LetterW-1:0] ring_mem [ssdm_pkg::MaxWordLen];

  logic [SlotW-1:0] clr_q;
  logic             cmd_q, last_q;
  logic [ssdm_pkg::LetterW-1:0] let_q;
  logic [ssdm_pkg::FreeW-1:0]   free_q;
  logic [NodeW-1:0] cur_q, node_q, rd_child_q;
  logic [LenW-1:0]  len_q, fill_q, k_q;
  logic             failed_q, end_rd_q;
  logic [PosW-1:0]  wpos_q, rpos_q;
  logic             match_q, stop_q;
  logic [1:0]       status_q;
  logic [ssdm_pkg::LetterW-1:0] c_q;

  // slot address for node*alphabet+letter
  function automatic logic [SlotW-1:0] slot_of(logic [NodeW-1:0] n,
                                               logic [ssdm_pkg::LetterW-1:0] l);
    logic [SlotW+ssdm_pkg::LetterW:0] s;
    s = (SlotW+ssdm_pkg::LetterW+1)'(n) * (SlotW+ssdm_pkg::LetterW+1)'(ssdm_pkg::Alphabet)
        + (SlotW+ssdm_pkg::LetterW+1)'(l);
    return s[SlotW-1:0];
  endfunction

  logic [SlotW-1:0] rd_addr;
  logic             wr_en, clr_end;
  logic [SlotW-1:0] wr_addr;
  logic [NodeW-1:0] wr_data;
  logic             ins_alpha, ins_new, ins_ok, ins_long, ins_full;
  logic             fend_we;
  logic [NodeW-1:0] fend_addr;
  logic [NodeW-1:0] new_cur;
  logic             c_bad;

  assign c_bad = c_q >= ssdm_pkg::LetterW'(ssdm_pkg::Alphabet);
  assign rd_addr = cmd_i.ins_read ? slot_of(cur_q, let_q)
                                  : slot_of(node_q, c_q);

  assign ins_alpha = let_q < ssdm_pkg::LetterW'(ssdm_pkg::Alphabet);
  assign ins_long  = ins_alpha && (len_q >= LenW'(ssdm_pkg::MaxWordLen));
  assign ins_new   = rd_child_q == '0;
  assign ins_full  = ins_alpha && !ins_long && ins_new &&
                     (free_q >= ssdm_pkg::FreeW'(ssdm_pkg::NodeCount));
  assign ins_ok    = !failed_q && ins_alpha && !ins_long && !ins_full;
  assign new_cur   = ins_new ? free_q[NodeW-1:0] : rd_child_q;

  assign clr_end = cmd_i.clear_step;
  assign wr_en   = cmd_i.clear_step || (cmd_i.ins_do && ins_ok && ins_new);
  assign wr_addr = cmd_i.clear_step ? clr_q : slot_of(cur_q, let_q);
  assign wr_data = cmd_i.clear_step ? '0 : free_q[NodeW-1:0];
  assign fend_we = clr_end ? (clr_q < SlotW'(ssdm_pkg::NodeCount))
                           : (cmd_i.ins_do && last_q && (ins_ok ||
                              (!failed_q && 1'b0)));
  assign fend_addr = clr_end ? clr_q[NodeW-1:0] : (ins_ok ? new_cur : cur_q);

  // read data held until the next lookup
  always_ff @(posedge clk_i) begin
    if (wr_en) child_mem[wr_addr] <= wr_data;
    if (cmd_i.ins_read || cmd_i.qry_read) rd_child_q <= child_mem[rd_addr];
  end

  // end flag memory; an insert that closes a word on a failed-free path sets it
  logic end_we_all;
  logic end_wd;
  assign end_we_all = fend_we || (cmd_i.ins_do && last_q && !failed_q && !ins_alpha
                                  && 1'b0);
  assign end_wd = !clr_end;
  always_ff @(posedge clk_i) begin
    if (end_we_all) end_mem[fend_addr] <= end_wd;
    end_rd_q <= end_mem[rd_child_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_read && cmd_q) ring_mem[wpos_q] <= let_q;
    if (cmd_i.qry_start || cmd_i.qry_step) c_q <= ring_mem[rpos_q];
  end

  assign sts_o.clear_last = clr_q == SlotW'(ssdm_pkg::SlotCount - 1);
  assign sts_o.is_query   = cmd_q;
  assign sts_o.qry_stop   = stop_q;
  assign match_o  = match_q;
  assign status_o = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0; free_q <= ssdm_pkg::FreeW'(1); cur_q <= '0; len_q <= '0;
      failed_q <= 1'b0; wpos_q <= '0; fill_q <= '0;
      cmd_q <= 1'b0; last_q <= 1'b0; let_q <= '0; node_q <= '0; k_q <= '0;
      rpos_q <= '0; match_q <= 1'b0; stop_q <= 1'b0; status_q <= ssdm_pkg::StatusOk;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + SlotW'(1);
      if (cmd_i.load) begin
        cmd_q <= command_i; let_q <= letter_i; last_q <= word_end_i;
        match_q <= 1'b0; status_q <= ssdm_pkg::StatusOk; stop_q <= 1'b0;
      end
      if (cmd_i.ins_read && cmd_q) begin
        wpos_q <= (wpos_q == PosW'(ssdm_pkg::MaxWordLen - 1)) ? '0 : wpos_q + PosW'(1);
        rpos_q <= wpos_q;
        if (fill_q < LenW'(ssdm_pkg::MaxWordLen)) fill_q <= fill_q + LenW'(1);
      end
      if (cmd_i.ins_do) begin
        if (!failed_q) begin
          if (ins_long) status_q <= ssdm_pkg::StatusLong;
          else if (ins_full) status_q <= ssdm_pkg::StatusFull;
        end
        if (ins_ok && ins_new) free_q <= free_q + ssdm_pkg::FreeW'(1);
        if (last_q) begin
          cur_q <= '0; len_q <= '0; failed_q <= 1'b0;
        end else if (!failed_q) begin
          if (ins_ok) begin
            cur_q <= new_cur; len_q <= len_q + LenW'(1);
          end else failed_q <= 1'b1;
        end
      end
      if (cmd_i.qry_start) begin
        node_q <= '0; k_q <= '0;
        rpos_q <= (rpos_q == '0) ? PosW'(ssdm_pkg::MaxWordLen - 1) : rpos_q - PosW'(1);
      end
      if (cmd_i.qry_read) stop_q <= c_bad;
      // a letter outside the alphabet ends the walk before its lookup is used
      if (cmd_i.qry_step && !stop_q) begin
        node_q <= rd_child_q;
        k_q <= k_q + LenW'(1);
        rpos_q <= (rpos_q == '0) ? PosW'(ssdm_pkg::MaxWordLen - 1) : rpos_q - PosW'(1);
        if (rd_child_q == '0) stop_q <= 1'b1;
        else if (end_rd_q) begin
          match_q <= 1'b1; stop_q <= 1'b1;
        end else if (k_q + LenW'(1) >= fill_q) stop_q <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/stream_suffix_dictionary_match.sv */
// top level of the stream suffix dictionary matcher
// after reset a clearing pass (one child slot per cycle) runs over every slot
// before the first request is taken; end flags are cleared in the same pass
// insert: read, wait and update states between accept and result; query: read, start,
// then a read, wait and step state per trie node walked, for walks of up to 32 letters
// one request at a time; the next is taken the cycle after the result leaves
`default_nettype none
module stream_suffix_dictionary_match (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       command_i,
  input  wire logic [4:0] letter_i,
  input  wire logic       word_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            match_o,
  output logic [1:0]      status_o
);
  ssdm_pkg::cmd_t cmd;
  ssdm_pkg::sts_t sts;

  // controller owns the handshake, datapath owns all storage
  ssdm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  ssdm_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .command_i, .letter_i, .word_end_i, .match_o, .status_o
  );
endmodule
`default_nettype wire

/* hw/rtl/ssdm_checker.sv */
// port-level checks for the matcher, bound to the top level
`default_nettype none
module ssdm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic       match_o,
  input wire logic [1:0] status_o
);
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(match_o && status_o != ssdm_pkg::StatusOk))
    else $error("match with error");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ssdm_pkg::StatusLong) else $error("bad status");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_o) && $stable(status_o))
    else $error("result dropped");
endmodule

bind stream_suffix_dictionary_match ssdm_checker u_chk (.*);
`default_nettype wire

/* bench/stream_suffix_dictionary_match_test.sv */
// testbench for the stream suffix dictionary matcher: reversed trie inserts and stream queries
`timescale 1ns / 1ps
module stream_suffix_dictionary_match_test;

  // command codes as carried on command_i
  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  typedef struct {
    logic       command;
    logic [4:0] letter;
    logic       word_end;
  } request_t;

  typedef struct {
    logic       match;
    logic [1:0] status;
  } answer_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic       command_i = CmdInsert;
  logic [4:0] letter_i = '0;
  logic       word_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       match_o;
  logic [1:0] status_o;

  stream_suffix_dictionary_match u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .letter_i    (letter_i),
    .word_end_i  (word_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .match_o     (match_o),
    .status_o    (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // stimulus waiting to be offered, answers waiting to arrive
  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int       mismatch_count = 0;
  int       accepted_count = 0;
  logic     req_taken = 1'b0;

  // shadow trie and stream history
  int unsigned trie_child[ssdm_pkg::SlotCount];
  bit          trie_end[ssdm_pkg::NodeCount];
  int unsigned free_node;
  int unsigned cursor_node;
  int unsigned word_len;
  bit          word_failed;
  logic [4:0]  history[ssdm_pkg::MaxWordLen];
  int unsigned hist_pos;
  int unsigned hist_fill;

  function automatic logic [1:0] trie_insert(logic [4:0] letter, logic last);
    logic [1:0]  status;
    int unsigned slot;
    int unsigned child;
    status = ssdm_pkg::StatusOk;
    if (!word_failed) begin
      if (letter >= ssdm_pkg::Alphabet) begin
        // letter outside the alphabet kills the word silently
        word_failed = 1'b1;
      end else if (word_len >= ssdm_pkg::MaxWordLen) begin
        word_failed = 1'b1;
        status = ssdm_pkg::StatusLong;
      end else begin
        slot = cursor_node * ssdm_pkg::Alphabet + letter;
        child = trie_child[slot];
        if (child == 0) begin
          if (free_node >= ssdm_pkg::NodeCount) begin
            word_failed = 1'b1;
            status = ssdm_pkg::StatusFull;
          end else begin
            child = free_node;
            free_node++;
            trie_child[slot] = child;
          end
        end
        if (!word_failed) begin
          cursor_node = child;
          word_len++;
        end
      end
    end
    // word end always closes the word, good or failed
    if (last) begin
      if (!word_failed) trie_end[cursor_node] = 1'b1;
      cursor_node = 0;
      word_len = 0;
      word_failed = 1'b0;
    end
    return status;
  endfunction

  function automatic logic stream_query(logic [4:0] letter);
    int unsigned node;
    int unsigned pos;
    int unsigned child;
    logic [4:0]  c;
    node = 0;
    history[hist_pos] = letter;
    hist_pos = (hist_pos + 1) % ssdm_pkg::MaxWordLen;
    if (hist_fill < ssdm_pkg::MaxWordLen) hist_fill++;
    // walk backwards from the newest letter
    for (int k = 0; k < hist_fill; k++) begin
      pos = (hist_pos + 2 * ssdm_pkg::MaxWordLen - 1 - k) % ssdm_pkg::MaxWordLen;
      c = history[pos];
      if (c >= ssdm_pkg::Alphabet) return 1'b0;
      child = trie_child[node * ssdm_pkg::Alphabet + c];
      if (child == 0) return 1'b0;
      node = child;
      if (trie_end[node]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // predict on accept, check on result; one request at a time so no overlap
  always @(posedge clk_i) begin
    answer_t exp_ans;
    req_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      accepted_count++;
      if (command_i == CmdInsert) begin
        exp_ans.match = 1'b0;
        exp_ans.status = trie_insert(letter_i, word_end_i);
      end else begin
        exp_ans.match = stream_query(letter_i);
        exp_ans.status = ssdm_pkg::StatusOk;
      end
      expected_answers.push_back(exp_ans);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        $error("result with nothing expected: match %0d status %0d", match_o, status_o);
        mismatch_count++;
      end else begin
        exp_ans = expected_answers.pop_front();
        if (match_o !== exp_ans.match) begin
          $error("match: expected %0d, got %0d", exp_ans.match, match_o);
          mismatch_count++;
        end
        if (status_o !== exp_ans.status) begin
          $error("status: expected %0d, got %0d", exp_ans.status, status_o);
          mismatch_count++;
        end
      end
    end
  end

  // idling stops in the last stretch of the run
  function automatic bit quiet();
    return pending_reqs.size() < 120;
  endfunction

  int send_gap = 0;
  always @(negedge clk_i) begin
    request_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        command_i  <= nxt.command;
        letter_i   <= nxt.letter;
        word_end_i <= nxt.word_end;
        in_valid_i <= 1'b1;
        if (!quiet() && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 11);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the block backs up
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (!hold_done && accepted_count >= 250) begin
      hold_done = 1'b1;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!quiet() && stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet() && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 11);
    end
  end

  task automatic add_req(logic command, logic [4:0] letter, logic word_end);
    request_t r;
    r.command = command;
    r.letter = letter;
    r.word_end = word_end;
    pending_reqs.push_back(r);
  endtask

  // word given reversed; word_end rides on the last item
  task automatic add_word(int len, int top_letter);
    for (int i = 0; i < len; i++)
      add_req(CmdInsert, 5'($urandom_range(0, top_letter)), i == len - 1);
  endtask

  task automatic add_random_query(int top_letter);
    logic [4:0] l;
    // now and then a code past the alphabet
    if ($urandom_range(0, 19) == 0) l = 5'($urandom_range(ssdm_pkg::Alphabet, 31));
    else l = 5'($urandom_range(0, top_letter));
    add_req(CmdQuery, l, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    free_node = 1;
    cursor_node = 0;
    word_len = 0;
    word_failed = 1'b0;
    hist_pos = 0;
    hist_fill = 0;

    // directed: short words, alphabet edges, bad letter, over-long word
    add_req(CmdInsert, 5'd0, 1'b1);
    add_req(CmdInsert, 5'd25, 1'b0);
    add_req(CmdInsert, 5'd1, 1'b1);
    add_req(CmdInsert, 5'd31, 1'b0);
    add_req(CmdInsert, 5'd2, 1'b1);
    for (int i = 0; i <= ssdm_pkg::MaxWordLen; i++)
      add_req(CmdInsert, 5'd3, i == ssdm_pkg::MaxWordLen);
    add_req(CmdQuery, 5'd1, 1'b1);
    add_req(CmdQuery, 5'd25, 1'b0);
    add_req(CmdQuery, 5'd0, 1'b1);
    add_req(CmdQuery, 5'd30, 1'b0);
    add_req(CmdQuery, 5'd1, 1'b0);
    add_req(CmdQuery, 5'd25, 1'b1);
    add_req(CmdQuery, 5'd3, 1'b0);
    add_req(CmdQuery, 5'd2, 1'b0);

    // random: small alphabet so queries hit often
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 9) == 0) add_req(CmdInsert, 5'($urandom_range(0, 31)), 1'b1);
        else add_word($urandom_range(1, 6), 3);
      end else begin
        add_random_query(3);
      end
    end

    // fill the node table with long words over the whole alphabet
    for (int w = 0; w < 33; w++) begin
      add_word($urandom_range(30, 32), ssdm_pkg::Alphabet - 1);
      add_random_query(ssdm_pkg::Alphabet - 1);
    end
    for (int i = 0; i < 20; i++) add_random_query(3);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_answers.size() != 0);
    repeat (150) @(posedge clk_i);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("stream_suffix_dictionary_match_test: done, clean");
    end else begin
      $display("stream_suffix_dictionary_match_test: done, errors");
    end
    $finish;
  end

  // covers the clearing pass, the slowest walks and all stalls several times over
  initial begin
    #4_000_000;
    $display("stream_suffix_dictionary_match_test: done, errors");
    $finish;
  end

endmodule

/* stream_suffix_dictionary_match.f */
hw/rtl/ssdm_pkg.sv
hw/rtl/ssdm_ctrl.sv
hw/rtl/ssdm_dp.sv
hw/rtl/stream_suffix_dictionary_match.sv
hw/rtl/ssdm_checker.sv
bench/stream_suffix_dictionary_match_test.sv
